// ===== sv/rspb_pkg.sv =====
package rspb_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   typedef enum logic [1:0] {
      KIND_PALETTE = 2'd0,
      KIND_SPRITE  = 2'd1,
      KIND_START   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_ROWCOUNT = 2'd0,
      PH_SKIP     = 2'd1,
      PH_COUNT    = 2'd2,
      PH_INDEX    = 2'd3
   } phase_type;

   localparam logic [2:0] REG_DEST_BASE   = 3'd0;
   localparam logic [2:0] REG_DEST_PITCH  = 3'd1;
   localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
   localparam logic [2:0] REG_ORIGIN_Y    = 3'd3;
   localparam logic [2:0] REG_SPRITE_ROWS = 3'd4;

   // result of one beat, apart from the color that comes out of the palette
   typedef struct packed {
      logic        write_valid;
      logic [31:0] write_address;
      logic        sprite_done;
      logic        stray_byte;
      logic        color_ok;
   } result_type;

endpackage

// ===== sv/rspb_palette_ram.sv =====
module rspb_palette_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [rspb_pkg::PAL_AW-1:0] wr_addr,
   input  logic [15:0]                wr_data,
   input  logic                       rd_en,
   input  logic [rspb_pkg::PAL_AW-1:0] rd_addr,
   output logic [15:0]                rd_data_ff
);
   import rspb_pkg::*;

   logic [15:0] mem [PALETTE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/rspb_parser.sv =====
module rspb_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_write_data,
   input  logic                 fire,
   input  logic [1:0]           kind,
   input  logic [7:0]           data_byte,
   output rspb_pkg::result_type result
);
   import rspb_pkg::*;

   logic [31:0] dest_base_ff;
   logic [15:0] dest_pitch_ff;
   logic [11:0] origin_x_ff;
   logic [11:0] origin_y_ff;
   logic [15:0] sprite_rows_ff;

   phase_type   phase_ff, phase_in;
   logic [7:0]  seg_ff, seg_in;
   logic [7:0]  pix_ff, pix_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [31:0] base_ff, base_in;
   logic        finished_ff, finished_in;

   logic [15:0] row_inc;
   logic        last_row;
   logic [7:0]  seg_dec;
   logic [7:0]  pix_dec;
   logic [31:0] start_base;
   logic [31:0] pix_addr;
   logic        idx_in_range;
   logic        sprite_live;

   assign row_inc      = row_ff + 16'd1;
   assign last_row     = (row_inc >= sprite_rows_ff);
   assign seg_dec      = seg_ff - 8'd1;
   assign pix_dec      = pix_ff - 8'd1;
   assign start_base   = dest_base_ff + 32'(origin_y_ff * dest_pitch_ff)
                         + 32'({origin_x_ff, 1'b0});
   assign pix_addr     = base_ff + 32'({col_ff, 1'b0});
   assign idx_in_range = ({1'b0, data_byte} < 9'(PALETTE_ENTRIES));
   assign sprite_live  = (kind == KIND_SPRITE) && !finished_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_base_ff   <= '0;
         dest_pitch_ff  <= '0;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         sprite_rows_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_DEST_BASE:   dest_base_ff   <= csr_write_data;
            REG_DEST_PITCH:  dest_pitch_ff  <= csr_write_data[15:0];
            REG_ORIGIN_X:    origin_x_ff    <= csr_write_data[11:0];
            REG_ORIGIN_Y:    origin_y_ff    <= csr_write_data[11:0];
            REG_SPRITE_ROWS: sprite_rows_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // next state of the parser
   always_comb begin
      logic end_seg;
      logic end_row;
      end_seg     = 1'b0;
      end_row     = 1'b0;
      phase_in    = phase_ff;
      seg_in      = seg_ff;
      pix_in      = pix_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      base_in     = base_ff;
      finished_in = finished_ff;
      if (kind == KIND_START) begin
         base_in     = start_base;
         phase_in    = PH_ROWCOUNT;
         seg_in      = '0;
         pix_in      = '0;
         row_in      = '0;
         col_in      = '0;
         finished_in = (sprite_rows_ff == 16'd0);
      end else if (sprite_live) begin
         case (phase_ff)
            PH_ROWCOUNT: begin
               seg_in = data_byte;
               if (data_byte == 8'd0) end_row = 1'b1;
               else phase_in = PH_SKIP;
            end
            PH_SKIP: begin
               col_in   = col_ff + 16'(data_byte);
               phase_in = PH_COUNT;
            end
            PH_COUNT: begin
               pix_in = data_byte;
               if (data_byte == 8'd0) end_seg = 1'b1;
               else phase_in = PH_INDEX;
            end
            PH_INDEX: begin
               col_in = col_ff + 16'd1;
               pix_in = pix_dec;
               if (pix_dec == 8'd0) end_seg = 1'b1;
            end
            default: ;
         endcase
         if (end_seg) begin
            seg_in = seg_dec;
            if (seg_dec == 8'd0) end_row = 1'b1;
            else phase_in = PH_SKIP;
         end
         if (end_row) begin
            row_in   = row_inc;
            col_in   = '0;
            base_in  = base_ff + 32'(dest_pitch_ff);
            phase_in = PH_ROWCOUNT;
            seg_in   = '0;
            pix_in   = '0;
            if (last_row) finished_in = 1'b1;
         end
      end
   end

   // result of the current beat
   always_comb begin
      logic ends_row;
      ends_row = 1'b0;
      result   = '0;
      if (kind == KIND_START) begin
         result.sprite_done = (sprite_rows_ff == 16'd0);
      end else if (kind == KIND_SPRITE && finished_ff) begin
         result.stray_byte = 1'b1;
      end else if (sprite_live) begin
         case (phase_ff)
            PH_ROWCOUNT: ends_row = (data_byte == 8'd0);
            PH_COUNT:    ends_row = (data_byte == 8'd0) && (seg_dec == 8'd0);
            PH_INDEX: begin
               result.write_valid   = 1'b1;
               result.write_address = pix_addr;
               result.color_ok      = idx_in_range;
               ends_row             = (pix_dec == 8'd0) && (seg_dec == 8'd0);
            end
            default: ;
         endcase
         result.sprite_done = ends_row && last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_ROWCOUNT;
         seg_ff      <= '0;
         pix_ff      <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         base_ff     <= '0;
         finished_ff <= 1'b1;
      end else if (fire) begin
         phase_ff    <= phase_in;
         seg_ff      <= seg_in;
         pix_ff      <= pix_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         base_ff     <= base_in;
         finished_ff <= finished_in;
      end
   end

endmodule

// ===== sv/rle_sprite_palette_blitter.sv =====
// Run-length sprite blitter: turns an encoded sprite byte stream into
// 16-bit framebuffer pixel writes through a palette memory.
// Request beats carry a kind: palette write (index, color), encoded
// sprite byte, or start. Every accepted beat gives exactly one response
// beat; only index bytes raise rsp_write_valid, the last row raises
// rsp_sprite_done and bytes after completion raise rsp_stray_byte.
// The user must write registers through the csr_ port only while the
// block is idle; this is not enforced. Start samples base, pitch and
// origin into the row address. A request passes the read stage (parser
// and synchronous palette read), then the output register.
// Throughput is one beat per cycle, set by the single palette read port.
// A stalled receiver holds the output register; one more beat is taken
// into the read stage, then req_ready drops until rsp_ready returns.
// Reset (synchronous) clears the parser to finished and the registers to
// zero; the palette holds no reset value and must be loaded before use.
module rle_sprite_palette_blitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [15:0] req_palette_color,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_valid,
   output logic [31:0] rsp_write_address,
   output logic [15:0] rsp_write_color,
   output logic        rsp_sprite_done,
   output logic        rsp_stray_byte
);
   import rspb_pkg::*;

   logic        fire;
   result_type  res;
   logic [15:0] rd_data;
   logic        pal_wr;
   logic        idx_ok;

   logic        a_valid_ff, a_valid_in;
   result_type  a_res_ff;
   logic        b_valid_ff, b_valid_in;
   result_type  b_res_ff;
   logic [15:0] b_color_ff;
   logic        b_free;
   logic        a_move;

   assign b_free    = !b_valid_ff || rsp_ready;
   assign a_move    = a_valid_ff && b_free;
   assign req_ready = !a_valid_ff || b_free;
   assign fire      = req_valid && req_ready;

   assign idx_ok = ({1'b0, req_palette_index} < 9'(PALETTE_ENTRIES));
   assign pal_wr = fire && (req_kind == KIND_PALETTE) && idx_ok;

   rspb_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fire             (fire),
      .kind             (req_kind),
      .data_byte        (req_data_byte),
      .result           (res)
   );

   // read only on accept so the data holds while the read stage stalls
   rspb_palette_ram u_ram (
      .clock      (clock),
      .wr_en      (pal_wr),
      .wr_addr    (req_palette_index[PAL_AW-1:0]),
      .wr_data    (req_palette_color),
      .rd_en      (fire),
      .rd_addr    (req_data_byte[PAL_AW-1:0]),
      .rd_data_ff (rd_data)
   );

   assign a_valid_in = fire || (a_valid_ff && !b_free);
   assign b_valid_in = a_move || (b_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         a_res_ff <= res;
      end
      if (a_move) begin
         b_res_ff   <= a_res_ff;
         b_color_ff <= a_res_ff.color_ok ? rd_data : 16'd0;
      end
   end

   assign rsp_valid         = b_valid_ff;
   assign rsp_write_valid   = b_res_ff.write_valid;
   assign rsp_write_address = b_res_ff.write_address;
   assign rsp_write_color   = b_color_ff;
   assign rsp_sprite_done   = b_res_ff.sprite_done;
   assign rsp_stray_byte    = b_res_ff.stray_byte;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_write_valid && rsp_stray_byte))
      else $error("pixel write and stray flag on one beat");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_valid) |->
         (rsp_write_address == 32'd0 && rsp_write_color == 16'd0))
      else $error("idle response carries address or color");

   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_free) |=> (a_valid_ff && $stable(a_res_ff)))
      else $error("read stage lost or changed a held beat");

   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !rsp_ready) |=> (b_valid_ff && $stable(b_color_ff)))
      else $error("output register changed under stall");

endmodule

// ===== test/pixel_write_checker.sv =====
module pixel_write_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [15:0] req_palette_color,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_write_valid,
   input  logic [31:0] rsp_write_address,
   input  logic [15:0] rsp_write_color,
   input  logic        rsp_sprite_done,
   input  logic        rsp_stray_byte,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rspb_pkg::*;

   typedef struct packed {
      logic        write_valid;
      logic [31:0] write_address;
      logic [15:0] write_color;
      logic        sprite_done;
      logic        stray_byte;
   } pixel_write_type;

   pixel_write_type expected_writes[$];

   logic [31:0] reg_base;
   logic [15:0] reg_pitch;
   logic [11:0] reg_ox;
   logic [11:0] reg_oy;
   logic [15:0] reg_rows;

   logic [15:0] pal_mem [PALETTE_ENTRIES];
   phase_type   phase;
   logic [7:0]  segs_left;
   logic [7:0]  pix_left;
   logic [15:0] row_num;
   logic [15:0] col_num;
   logic [31:0] row_addr;
   logic        done_flag;

   // Return 1 when the closed row was the last one.
   function automatic logic close_row();
      row_num = row_num + 16'd1;
      col_num = '0;
      row_addr = row_addr + 32'(reg_pitch);
      phase = PH_ROWCOUNT;
      segs_left = '0;
      pix_left = '0;
      if (row_num >= reg_rows) begin
         done_flag = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic close_segment();
      segs_left = segs_left - 8'd1;
      if (segs_left == 8'd0) return close_row();
      phase = PH_SKIP;
      return 1'b0;
   endfunction

   function automatic pixel_write_type predict_pixel_write(logic [1:0] kind, logic [7:0] data,
                                                           logic [7:0] pidx, logic [15:0] pcol);
      pixel_write_type r;
      r = '0;
      case (kind)
         KIND_PALETTE: begin
            if (int'(pidx) < PALETTE_ENTRIES) pal_mem[pidx] = pcol;
         end
         KIND_START: begin
            row_addr = reg_base + 32'(reg_oy) * 32'(reg_pitch) + 32'(reg_ox) * 32'd2;
            phase = PH_ROWCOUNT;
            segs_left = '0;
            pix_left = '0;
            row_num = '0;
            col_num = '0;
            done_flag = (reg_rows == 16'd0);
            r.sprite_done = done_flag;
         end
         KIND_SPRITE: begin
            if (done_flag) begin
               r.stray_byte = 1'b1;
            end else begin
               case (phase)
                  PH_ROWCOUNT: begin
                     segs_left = data;
                     if (data == 8'd0) r.sprite_done = close_row();
                     else phase = PH_SKIP;
                  end
                  PH_SKIP: begin
                     col_num = col_num + 16'(data);
                     phase = PH_COUNT;
                  end
                  PH_COUNT: begin
                     pix_left = data;
                     if (data == 8'd0) r.sprite_done = close_segment();
                     else phase = PH_INDEX;
                  end
                  default: begin
                     r.write_valid = 1'b1;
                     r.write_address = row_addr + {15'd0, col_num, 1'b0};
                     r.write_color = (int'(data) < PALETTE_ENTRIES) ? pal_mem[data] : 16'h0;
                     col_num = col_num + 16'd1;
                     pix_left = pix_left - 8'd1;
                     if (pix_left == 8'd0) r.sprite_done = close_segment();
                  end
               endcase
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_write_type want;
      if (reset) begin
         reg_base = '0;
         reg_pitch = '0;
         reg_ox = '0;
         reg_oy = '0;
         reg_rows = '0;
         phase = PH_ROWCOUNT;
         segs_left = '0;
         pix_left = '0;
         row_num = '0;
         col_num = '0;
         row_addr = '0;
         done_flag = 1'b1;
         fail_count = 0;
         expected_writes.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_DEST_BASE:   reg_base = csr_write_data;
               REG_DEST_PITCH:  reg_pitch = csr_write_data[15:0];
               REG_ORIGIN_X:    reg_ox = csr_write_data[11:0];
               REG_ORIGIN_Y:    reg_oy = csr_write_data[11:0];
               REG_SPRITE_ROWS: reg_rows = csr_write_data[15:0];
               default: ;
            endcase
         end
         // compare before queueing: a beat taken this edge cannot answer yet
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               $error("response beat with no request waiting");
               fail_count++;
            end else begin
               want = expected_writes.pop_front();
               check_field("write_valid", want.write_valid, rsp_write_valid);
               check_field("write_address", want.write_address, rsp_write_address);
               check_field("write_color", want.write_color, rsp_write_color);
               check_field("sprite_done", want.sprite_done, rsp_sprite_done);
               check_field("stray_byte", want.stray_byte, rsp_stray_byte);
            end
         end
         if (req_valid && req_ready) begin
            want = predict_pixel_write(req_kind, req_data_byte,
                                       req_palette_index, req_palette_color);
            expected_writes.insert(expected_writes.size(), want);
         end
      end
      pending <= expected_writes.size();
   end

endmodule

// ===== test/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rspb_pkg::*;

   localparam logic [1:0] KIND_RESERVED = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 380;
   localparam int PHASES = 12;
   localparam int LONG_HOLD = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = '0;
   logic [7:0]  req_data_byte = '0;
   logic [7:0]  req_palette_index = '0;
   logic [15:0] req_palette_color = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_write_valid;
   logic [31:0] rsp_write_address;
   logic [15:0] rsp_write_color;
   logic        rsp_sprite_done;
   logic        rsp_stray_byte;

   int fail_count;
   int pending;

   logic [15:0] cfg_rows = '0;
   bit          sprite_open = 1'b0;
   bit          hold_rsp = 1'b0;
   bit          send_fast = 1'b0;
   int          send_count = 0;
   int          items_sent = 0;
   logic [7:0]  loaded_list[$];
   bit          loaded_flag[256];

   always #5ns clock = ~clock;

   rle_sprite_palette_blitter DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_data_byte     (req_data_byte),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_address (rsp_write_address),
      .rsp_write_color   (rsp_write_color),
      .rsp_sprite_done   (rsp_sprite_done),
      .rsp_stray_byte    (rsp_stray_byte)
   );

   pixel_write_checker write_check (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_data_byte     (req_data_byte),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_address (rsp_write_address),
      .rsp_write_color   (rsp_write_color),
      .rsp_sprite_done   (rsp_sprite_done),
      .rsp_stray_byte    (rsp_stray_byte),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // Keep valid high across back-to-back beats; drop it only before a gap.
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] data,
                            input logic [7:0] pidx, input logic [15:0] pcol);
      int gap;
      if (send_count % 40 == 0) send_fast = ($urandom_range(0, 3) == 0);
      send_count++;
      gap = send_fast ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_data_byte <= data;
      req_palette_index <= pidx;
      req_palette_color <= pcol;
      do @(posedge clock); while (!req_ready);
      if (kind != KIND_RESERVED) items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] data);
      send_beat(KIND_SPRITE, data, 8'($urandom), 16'($urandom));
   endtask

   task automatic send_start();
      send_beat(KIND_START, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic send_palette(input logic [7:0] pidx, input logic [15:0] pcol);
      if (!loaded_flag[pidx]) begin
         loaded_flag[pidx] = 1'b1;
         loaded_list.insert(loaded_list.size(), pidx);
      end
      send_beat(KIND_PALETTE, 8'($urandom), pidx, pcol);
   endtask

   task automatic send_noise();
      if ($urandom_range(0, 1) == 0)
         send_palette(8'($urandom), 16'($urandom));
      else
         send_beat(KIND_RESERVED, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   // Only entries already loaded may be read back.
   function automatic logic [7:0] pick_index();
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   function automatic void add_row(ref logic [7:0] bq[$]);
      int nseg;
      int npix;
      nseg = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      bq.insert(bq.size(), 8'(nseg));
      for (int s = 0; s < nseg; s++) begin
         npix = ($urandom_range(0, 29) == 0) ? $urandom_range(7, 64) : $urandom_range(0, 5);
         bq.insert(bq.size(), 8'($urandom));
         bq.insert(bq.size(), 8'(npix));
         for (int i = 0; i < npix; i++) bq.insert(bq.size(), pick_index());
      end
   endfunction

   // 255 segments of maximum skip; the last pixels run the column past 16 bits.
   function automatic void add_wide_row(ref logic [7:0] bq[$]);
      int npix;
      bq.insert(bq.size(), 8'd255);
      for (int s = 1; s <= 255; s++) begin
         npix = (s < 253) ? 0 : (s < 255) ? 255 : 8;
         bq.insert(bq.size(), 8'd255);
         bq.insert(bq.size(), 8'(npix));
         for (int i = 0; i < npix; i++) bq.insert(bq.size(), pick_index());
      end
   endfunction

   task automatic run_sprite(input bit wide);
      logic [7:0] bq[$];
      int nrows;
      int keep;
      bit cut;
      cut = 1'b0;
      if (wide) nrows = 1;
      else if (cfg_rows <= 16'd6) nrows = int'(cfg_rows);
      else nrows = $urandom_range(1, 3);
      for (int r = 0; r < nrows; r++) begin
         if (wide) add_wide_row(bq);
         else add_row(bq);
      end
      // abandon some sprites part way
      if (!wide && bq.size() > 1 && $urandom_range(0, 7) == 0) begin
         keep = $urandom_range(1, bq.size() - 1);
         while (bq.size() > keep) void'(bq.pop_back());
         cut = 1'b1;
      end
      send_start();
      foreach (bq[i]) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         send_byte(bq[i]);
      end
      sprite_open = cut || (nrows != int'(cfg_rows));
      if (!sprite_open) repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   task automatic write_config(input logic [31:0] base, input logic [15:0] pitch,
                               input logic [11:0] ox, input logic [11:0] oy,
                               input logic [15:0] rows);
      write_reg(REG_DEST_BASE, base);
      write_reg(REG_DEST_PITCH, 32'(pitch));
      write_reg(REG_ORIGIN_X, 32'(ox));
      write_reg(REG_ORIGIN_Y, 32'(oy));
      write_reg(REG_SPRITE_ROWS, 32'(rows));
      csr_write_enable <= 1'b0;
      cfg_rows = rows;
   endtask

   // Hold off until every response is back, then let the pipe empty.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] draw_reg(int bits);
      logic [31:0] mask;
      mask = (bits >= 32) ? 32'hFFFF_FFFF : (32'd1 << bits) - 32'd1;
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return mask;
         default: return $urandom & mask;
      endcase
   endfunction

   initial begin : receiver
      int stall;
      int beats;
      bit fast;
      beats = 0;
      fast = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (beats % 40 == 0) fast = ($urandom_range(0, 3) == 0);
         beats++;
         if (hold_rsp) begin
            stall = LONG_HOLD;
            hold_rsp = 1'b0;
         end else begin
            stall = fast ? 0 : $urandom_range(0, 19);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int goal;
      int wide_items;
      wide_items = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: address wrap, empty row, empty segment, stray, reserved kind
      write_config(32'hFFFF_FFFE, 16'hFFFF, 12'hFFF, 12'hFFF, 16'd2);
      send_palette(8'd0, 16'hFFFF);
      send_palette(8'd255, 16'h8001);
      send_palette(8'd170, 16'h5A5A);
      send_byte(8'hFF);
      send_beat(KIND_RESERVED, 8'hFF, 8'hFF, 16'hFFFF);
      send_start();
      send_byte(8'd0);
      send_byte(8'd2);
      send_byte(8'd255);
      send_byte(8'd0);
      send_byte(8'd0);
      send_byte(8'd2);
      send_byte(8'd0);
      send_byte(8'd255);
      send_byte(8'h5A);
      send_start();
      send_byte(8'd1);
      send_byte(8'd3);
      send_byte(8'd5);
      // overwrite an entry right before it is read
      send_palette(8'd170, 16'h1234);
      send_byte(8'd170);
      send_start();
      sprite_open = 1'b1;

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: write_config('0, '0, '0, '0, '0);
            1: write_config(32'hFFFF_FFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF);
            2: write_config(draw_reg(32), 16'(draw_reg(16)), 12'(draw_reg(12)),
                            12'(draw_reg(12)), 16'd1);
            default: begin
               case ($urandom_range(0, 5))
                  0: goal = 0;
                  1: goal = $urandom_range(7, 65535);
                  default: goal = $urandom_range(1, 5);
               endcase
               write_config(draw_reg(32), 16'(draw_reg(16)), 12'(draw_reg(12)),
                            12'(draw_reg(12)), 16'(goal));
            end
         endcase
         if (p == 2) begin
            wide_items = items_sent;
            run_sprite(1'b1);
            wide_items = items_sent - wide_items;
         end
         if (p == 4) hold_rsp = 1'b1;
         // the wide row counts toward the total, so the random share stays bounded
         goal = wide_items + RANDOM_ITEMS * (p + 1) / PHASES;
         while (items_sent < goal) begin
            case ($urandom_range(0, 9))
               0: repeat ($urandom_range(1, 4)) send_palette(8'($urandom), 16'($urandom));
               1: begin
                  if (sprite_open) send_noise();
                  else repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
               end
               default: run_sprite(1'b0);
            endcase
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/rspb_pkg.sv
sv/rspb_palette_ram.sv
sv/rspb_parser.sv
sv/rle_sprite_palette_blitter.sv
test/pixel_write_checker.sv
test/tb.sv
